/* sv/tcw_pkg.sv */
// shared types and constants for the text console writer
// field widths, operation and character codes, cell layout; no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    // default geometry
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 4;

    // fixed field widths
    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int ROW_FW     = 5;
    localparam int COL_FW     = 7;
    localparam int ATTR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

    // register reset values
    localparam logic [COLOR_W-1:0] RESET_FG   = 4'd7;
    localparam logic [COLOR_W-1:0] RESET_BG   = 4'd0;
    localparam logic [ATTR_W-1:0]  RESET_ATTR = 8'h07;

    // one screen cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] chr;
    } t_cell;

endpackage

/* sv/text_console_writer_unit.sv */
// text console writer: character-cell screen store, cursor and put/clear/read engine
// depends on tcw_pkg; the screen store is a one-port-write, one-port-read memory inside
`timescale 1ns / 1ps

// Usage
//   input channel (i_in_valid / o_in_stall): one beat is one operation, func put,
//   clear or read, with the character code and the read coordinates alongside.
//   output channel (o_out_valid / i_out_stall): one beat per operation with the
//   cursor after the operation and, for an in-range read, the cell contents (else zero).
//   config port: i_cfg_we with i_cfg_idx selects foreground or background colour.
// Operation flow, one operation at a time, from the input beat
//   put of a printable code, return or newline: done in the execute state
//   put of a tab: writes 1 .. TAB_WIDTH spaces, one at a time
//   read: the cell comes through the registered memory read
//   clear: every cell blanked, one cell written per cycle
//   any put that runs off the bottom row adds a scroll of the whole screen:
//   one cell copied per cycle, then the bottom row blanked
// The single write port of the screen memory sets this pace.
// Reset: the cursor homes and a clearing pass over all ROWS*COLUMNS cells fills the
//   screen with blanks (attribute 0x07); o_in_stall stays high during it, config
//   writes are still taken.
// A stalled result waits in the output register; the next operation is taken
//   and runs, then holds in a finish state until the output register frees.

module text_console_writer_unit #(
    parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcw_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // operation beats
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [tcw_pkg::FUNC_W-1:0]      i_func,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcw_pkg::ROW_FW-1:0]      i_read_row,
    input  logic [tcw_pkg::COL_FW-1:0]      i_read_col,
    // result beats
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tcw_pkg::ROW_FW-1:0]      o_cursor_row,
    output logic [tcw_pkg::COL_FW-1:0]      o_cursor_col,
    output logic [tcw_pkg::CHAR_W-1:0]      o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]      o_cell_attr,
    // colour registers
    input  logic                            i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int MOVE_N = (ROWS - 1) * COLUMNS;   // cells moved up by a scroll
    localparam int AW     = $clog2(CELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int PW     = $clog2(TAB_WIDTH);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;   // waiting for an operation beat
    localparam logic [2:0] S_EXEC   = 3'd1;   // decode and do the single-cell part
    localparam logic [2:0] S_TAB    = 3'd2;   // one tab space per cycle
    localparam logic [2:0] S_SCROLL = 3'd3;   // copy each cell one row up
    localparam logic [2:0] S_FILL   = 3'd4;   // blank a run of cells
    localparam logic [2:0] S_FINISH = 3'd5;   // result waits for read data or for the output register

    logic [2:0]          r_state, n_state;
    logic [RW-1:0]       r_row, n_row;
    logic [CW-1:0]       r_col, n_col;
    logic [PW-1:0]       r_phase, n_phase;     // column modulo tab width
    logic [AW-1:0]       r_idx, n_idx;         // sweep pointer for scroll and fill
    logic                r_pend, n_pend;       // scroll read in flight
    logic                r_init, n_init;       // clearing pass after reset
    logic [ATTR_W-1:0]   r_fill_attr, n_fill_attr;
    logic                r_rd_hit, n_rd_hit;   // read op found an in-range cell

    // latched operation
    logic [FUNC_W-1:0]   r_func;
    logic [CHAR_W-1:0]   r_char;
    logic [ROW_FW-1:0]   r_rrow;
    logic [COL_FW-1:0]   r_rcol;

    // colour registers
    logic [COLOR_W-1:0]  r_fg;
    logic [COLOR_W-1:0]  r_bg;

    // output register
    logic                r_out_valid;
    logic [ROW_FW-1:0]   r_out_row;
    logic [COL_FW-1:0]   r_out_col;
    logic [CHAR_W-1:0]   r_out_char;
    logic [ATTR_W-1:0]   r_out_attr;

    // screen memory
    t_cell               r_mem [CELLS];
    t_cell               r_rd_data;
    logic                w_we;
    logic [AW-1:0]       w_wa;
    t_cell               w_wd;
    logic                w_re;
    logic [AW-1:0]       w_ra;

    logic                w_accept;
    logic                w_out_free;
    logic                w_done;
    logic [ATTR_W-1:0]   w_cur_attr;
    logic [AW-1:0]       w_cur_addr;
    logic [AW-1:0]       w_rd_addr;
    logic                w_rd_in_range;
    logic                w_last_col;
    logic                w_last_row;
    logic                w_last_phase;
    logic [RW-1:0]       w_row_inc;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_cur_attr = {r_bg, r_fg};
    assign w_cur_addr = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);

    // read coordinates are range-checked; only an in-range cell is read
    assign w_rd_in_range = (32'(r_rrow) < 32'(ROWS)) && (32'(r_rcol) < 32'(COLUMNS));
    assign w_rd_addr     = AW'(r_rrow) * AW'(COLUMNS) + AW'(r_rcol);

    assign w_last_col   = (r_col == CW'(COLUMNS - 1));
    assign w_last_row   = (r_row == RW'(ROWS - 1));
    assign w_last_phase = (r_phase == PW'(TAB_WIDTH - 1));
    // on the bottom row the cursor row stays put and the screen scrolls instead
    assign w_row_inc    = w_last_row ? r_row : r_row + RW'(1);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_init      = r_init;
        n_fill_attr = r_fill_attr;
        n_rd_hit    = r_rd_hit;
        w_we        = 1'b0;
        w_wa        = w_cur_addr;
        w_wd        = '{attr: w_cur_attr, chr: r_char};
        w_re        = 1'b0;
        w_ra        = w_rd_addr;
        w_done      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_EXEC;
                    n_rd_hit = 1'b0;
                end
            end

            S_EXEC: begin
                case (r_func)
                    FUNC_PUT: begin
                        case (r_char)
                            CHAR_NEWLINE: begin
                                n_col   = '0;
                                n_phase = '0;
                                n_row   = w_row_inc;
                                if (w_last_row) begin
                                    n_state = S_SCROLL;
                                    n_idx   = '0;
                                    n_pend  = 1'b0;
                                end else begin
                                    w_done = 1'b1;
                                end
                            end
                            CHAR_RETURN: begin
                                n_col   = '0;
                                n_phase = '0;
                                w_done  = 1'b1;
                            end
                            CHAR_TAB: begin
                                n_state = S_TAB;
                            end
                            default: begin
                                // printable code, written at the cursor
                                w_we = 1'b1;
                                if (w_last_col) begin
                                    n_col   = '0;
                                    n_phase = '0;
                                    n_row   = w_row_inc;
                                    if (w_last_row) begin
                                        n_state = S_SCROLL;
                                        n_idx   = '0;
                                        n_pend  = 1'b0;
                                    end else begin
                                        w_done = 1'b1;
                                    end
                                end else begin
                                    n_col   = r_col + CW'(1);
                                    n_phase = w_last_phase ? '0 : r_phase + PW'(1);
                                    w_done  = 1'b1;
                                end
                            end
                        endcase
                    end
                    FUNC_CLEAR: begin
                        n_row       = '0;
                        n_col       = '0;
                        n_phase     = '0;
                        n_idx       = '0;
                        n_fill_attr = w_cur_attr;
                        n_state     = S_FILL;
                    end
                    FUNC_READ: begin
                        // data lands in r_rd_data for the finish state
                        if (w_rd_in_range) begin
                            w_re     = 1'b1;
                            n_rd_hit = 1'b1;
                        end
                        n_state = S_FINISH;
                    end
                    default: begin
                        w_done = 1'b1;
                    end
                endcase
            end

            S_TAB: begin
                w_we = 1'b1;
                w_wd = '{attr: w_cur_attr, chr: CHAR_SPACE};
                if (w_last_col) begin
                    // tab reaching the line end wraps like a printed character
                    n_col   = '0;
                    n_phase = '0;
                    n_row   = w_row_inc;
                    if (w_last_row) begin
                        n_state = S_SCROLL;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                    end else begin
                        w_done = 1'b1;
                    end
                end else if (w_last_phase) begin
                    n_col   = r_col + CW'(1);
                    n_phase = '0;
                    w_done  = 1'b1;
                end else begin
                    n_col   = r_col + CW'(1);
                    n_phase = r_phase + PW'(1);
                end
            end

            S_SCROLL: begin
                // read one row ahead, write the cell read in the previous cycle;
                // the read address always leads the write address
                w_re   = (r_idx != AW'(MOVE_N));
                w_ra   = r_idx + AW'(COLUMNS);
                w_we   = r_pend;
                w_wa   = r_idx - AW'(1);
                w_wd   = r_rd_data;
                n_pend = w_re;
                if (r_idx == AW'(MOVE_N)) begin
                    n_state     = S_FILL;
                    n_fill_attr = w_cur_attr;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end

            S_FILL: begin
                w_we = 1'b1;
                w_wa = r_idx;
                w_wd = '{attr: r_fill_attr, chr: CHAR_SPACE};
                if (r_idx == AW'(CELLS - 1)) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        w_done = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end

            S_FINISH: begin
                w_done = 1'b1;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a finished operation goes straight out or parks until the output frees
        if (w_done) begin
            n_state = w_out_free ? S_IDLE : S_FINISH;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_init      <= 1'b1;
            r_fill_attr <= RESET_ATTR;
            r_rd_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_init      <= n_init;
            r_fill_attr <= n_fill_attr;
            r_rd_hit    <= n_rd_hit;
            if (w_done && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // colour registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= RESET_FG;
            r_bg <= RESET_BG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FG:  r_fg <= i_cfg_data[COLOR_W-1:0];
                CFG_BG:  r_bg <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // operation payload, taken on the input beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_char <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
    end

    // result payload; the cursor fields carry the value after this edge
    always_ff @(posedge i_clk) begin
        if (w_done && w_out_free) begin
            r_out_row  <= ROW_FW'(n_row);
            r_out_col  <= COL_FW'(n_col);
            r_out_char <= r_rd_hit ? r_rd_data.chr  : '0;
            r_out_attr <= r_rd_hit ? r_rd_data.attr : '0;
        end
    end

    // screen memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;

endmodule

/* sv/tcw_checker.sv */
// port-level checks for the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer_unit
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [tcw_pkg::ROW_FW-1:0]      o_cursor_row,
    input logic [tcw_pkg::COL_FW-1:0]      o_cursor_col,
    input logic [tcw_pkg::CHAR_W-1:0]      o_cell_char,
    input logic [tcw_pkg::ATTR_W-1:0]      o_cell_attr
);

    import tcw_pkg::*;

    // after reset the clearing pass holds off input and no result is pending
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("clearing pass not running after reset");

    // one operation at a time: an input beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a beat");

    // the reported cursor always lies on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((32'(o_cursor_col) < 32'(COLUMNS))
                         && (32'(o_cursor_row) < 32'(ROWS))))
        else $error("cursor off screen");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_cursor_row)
            && $stable(o_cursor_col) && $stable(o_cell_char) && $stable(o_cell_attr)))
        else $error("stalled result changed");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (.*);
